// ----- hdl/lgrs_pkg.sv -----
package lgrs_pkg;

  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned ROW_W      = MAX_WIDTH;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned WIDTH_W    = 7;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NBR_W      = 8;
  localparam int unsigned NCNT_W     = 4;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(64);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 4'd0,
    CFG_GRID_HEIGHT = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ROW_W-1:0] next_row;
    logic [IDX_W-1:0] row_index;
    logic             final_row;
  } row_res_t;

  typedef struct packed {
    logic     first_vld;
    logic     second_vld;
    row_res_t first;
    row_res_t second;
  } push_t;

  // bit k set when column k is inside the grid; width already saturated to 1..MAX_WIDTH
  function automatic logic [ROW_W-1:0] lane_mask(input logic [WIDTH_W-1:0] width);
    logic [ROW_W-1:0] m;
    for (int k = 0; k < ROW_W; k++) begin
      m[k] = (WIDTH_W'(k) < width);
    end
    return m;
  endfunction

endpackage

// ----- hdl/lgrs_if.sv -----
interface lgrs_in_if;
  logic                      valid;
  logic                      ready;
  logic [lgrs_pkg::ROW_W-1:0] row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

interface lgrs_out_if;
  logic                      valid;
  logic                      ready;
  logic [lgrs_pkg::ROW_W-1:0] next_row;
  logic [lgrs_pkg::IDX_W-1:0] row_index;
  logic                      final_row;

  modport source (output valid, output next_row, output row_index, output final_row,
                  input ready);
  modport sink   (input valid, input next_row, input row_index, input final_row,
                  output ready);
endinterface

interface lgrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lgrs_pkg::CFG_IDX_W-1:0]  index;
  logic [lgrs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/lgrs_lane.sv -----
module lgrs_lane (
  input  logic [lgrs_pkg::NBR_W-1:0] nbr_i,
  input  logic                       alive_i,
  output logic                       alive_o
);

  logic [lgrs_pkg::NCNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < lgrs_pkg::NBR_W; j++) begin
      cnt = cnt + lgrs_pkg::NCNT_W'(nbr_i[j]);
    end
  end

  // B3/S23
  assign alive_o = (cnt == lgrs_pkg::NCNT_W'(3)) || (alive_i && (cnt == lgrs_pkg::NCNT_W'(2)));

endmodule

// ----- hdl/lgrs_row_engine.sv -----
module lgrs_row_engine (
  input  logic [lgrs_pkg::ROW_W-1:0] up_i,
  input  logic [lgrs_pkg::ROW_W-1:0] mid_i,
  input  logic [lgrs_pkg::ROW_W-1:0] down_i,
  input  logic [lgrs_pkg::ROW_W-1:0] mask_i,
  output logic [lgrs_pkg::ROW_W-1:0] row_o
);

  // dead border on both sides
  logic [lgrs_pkg::ROW_W+1:0] up_x, mid_x, dn_x;
  logic [lgrs_pkg::ROW_W-1:0] lane_res;

  assign up_x  = {1'b0, up_i, 1'b0};
  assign mid_x = {1'b0, mid_i, 1'b0};
  assign dn_x  = {1'b0, down_i, 1'b0};

  for (genvar k = 0; k < lgrs_pkg::ROW_W; k++) begin : g_lane
    lgrs_lane u_lane (
      .nbr_i   ({up_x[k], up_x[k+1], up_x[k+2],
                 mid_x[k], mid_x[k+2],
                 dn_x[k], dn_x[k+1], dn_x[k+2]}),
      .alive_i (mid_x[k+1]),
      .alive_o (lane_res[k])
    );
  end

  assign row_o = lane_res & mask_i;

endmodule

// ----- hdl/lgrs_out_fifo.sv -----
module lgrs_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lgrs_pkg::push_t     push_i,
  output logic                space_o,
  lgrs_out_if.source          out_o
);

  lgrs_pkg::row_res_t mem_q [lgrs_pkg::FIFO_DEPTH];
  logic [lgrs_pkg::FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lgrs_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [lgrs_pkg::FIFO_PTR_W-1:0] wptr_nx;
  logic [lgrs_pkg::FIFO_CNT_W-1:0] n_push;
  logic pop;

  assign pop     = out_o.valid && out_o.ready;
  assign wptr_nx = wptr_q + lgrs_pkg::FIFO_PTR_W'(1);
  assign n_push  = lgrs_pkg::FIFO_CNT_W'(push_i.first_vld) +
                   lgrs_pkg::FIFO_CNT_W'(push_i.second_vld);

  // room for a full two-result request
  assign space_o = (cnt_q <= lgrs_pkg::FIFO_CNT_W'(lgrs_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + lgrs_pkg::FIFO_PTR_W'(n_push);
    rptr_d = pop ? rptr_q + lgrs_pkg::FIFO_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + n_push - lgrs_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.second_vld) begin
      mem_q[wptr_nx] <= push_i.second;
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.next_row  = mem_q[rptr_q].next_row;
  assign out_o.row_index = mem_q[rptr_q].row_index;
  assign out_o.final_row = mem_q[rptr_q].final_row;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lgrs_pkg::FIFO_CNT_W'(lgrs_pkg::FIFO_DEPTH))
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first_vld |-> space_o)
    else $error("push without room for two entries");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second_vld |-> push_i.first_vld)
    else $error("second result pushed without first");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.first_vld) |=> (cnt_q == $past(cnt_q) - lgrs_pkg::FIFO_CNT_W'(1)))
    else $error("occupancy not decremented on pop");
`endif

endmodule

// ----- hdl/life_generation_row_stencil_unit.sv -----
// One generation of Life (B3/S23) over a grid streamed one row per request,
// top row first; bit k of a row is column k.
// in_i   : row requests (valid/ready), accepted when both are high.
// out_o  : next-generation rows with their row index and a final-row flag.
// cfg_i  : register writes, always ready; index 0 = grid width (1..64),
//          index 1 = grid height (1..4096). Write only while the block is idle.
// Row r is produced when row r+1 is accepted; the last row of the grid
// produces two results (row r-1 and the flushed final row). A one-row grid
// produces one result per input.
// Each result is written into the output queue when its row is accepted.
// Throughput: one row per cycle, set by the 64 cell lanes of each row engine; in_i.ready
// is low while the four-entry output queue has fewer than two free entries.
// A stalled receiver fills the queue and then holds off in_i.
// Reset clears the stored rows and the row count and sets width and height
// to 64; the output queue comes up empty.
module life_generation_row_stencil_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lgrs_in_if.sink    in_i,
  lgrs_out_if.source out_o,
  lgrs_cfg_if.sink   cfg_i
);

  logic [lgrs_pkg::WIDTH_W-1:0]  width_q, width_d;
  logic [lgrs_pkg::HEIGHT_W-1:0] height_q, height_d;
  logic [lgrs_pkg::ROW_W-1:0]    above_q, above_d, mid_q, mid_d;
  logic [lgrs_pkg::IDX_W-1:0]    rows_q, rows_d;

  logic [lgrs_pkg::WIDTH_W-1:0]  w_eff;
  logic [lgrs_pkg::HEIGHT_W-1:0] h_eff;
  logic [lgrs_pkg::ROW_W-1:0]    mask, cur;
  logic [lgrs_pkg::ROW_W-1:0]    e0_up, e0_mid, e0_dn, e0_row, e1_row;
  logic first_row, last_row, single, accept, space;
  lgrs_pkg::push_t push;

  assign w_eff = (width_q == '0) ? lgrs_pkg::WIDTH_W'(1) :
                 (width_q > lgrs_pkg::WIDTH_W'(lgrs_pkg::MAX_WIDTH)) ?
                 lgrs_pkg::WIDTH_W'(lgrs_pkg::MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? lgrs_pkg::HEIGHT_W'(1) :
                 (height_q > lgrs_pkg::HEIGHT_W'(lgrs_pkg::MAX_HEIGHT)) ?
                 lgrs_pkg::HEIGHT_W'(lgrs_pkg::MAX_HEIGHT) : height_q;

  assign mask      = lgrs_pkg::lane_mask(w_eff);
  assign cur       = in_i.row_cells & mask;
  assign first_row = (rows_q == '0);
  assign single    = (h_eff == lgrs_pkg::HEIGHT_W'(1));
  assign last_row  = ((lgrs_pkg::HEIGHT_W'(rows_q) + lgrs_pkg::HEIGHT_W'(1)) >= h_eff);

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;
  assign cfg_i.ready = 1'b1;

  // engine 0: pending row (or a lone row for a one-row grid)
  assign e0_up  = first_row ? '0  : above_q;
  assign e0_mid = first_row ? cur : mid_q;
  assign e0_dn  = first_row ? '0  : cur;

  lgrs_row_engine u_eng_pend (
    .up_i   (e0_up),
    .mid_i  (e0_mid),
    .down_i (e0_dn),
    .mask_i (mask),
    .row_o  (e0_row)
  );

  // engine 1: flushed final row
  lgrs_row_engine u_eng_flush (
    .up_i   (mid_q),
    .mid_i  (cur),
    .down_i ('0),
    .mask_i (mask),
    .row_o  (e1_row)
  );

  always_comb begin
    push.first_vld        = 1'b0;
    push.second_vld       = 1'b0;
    push.first.next_row   = e0_row;
    push.first.row_index  = rows_q - lgrs_pkg::IDX_W'(1);
    push.first.final_row  = 1'b0;
    push.second.next_row  = e1_row;
    push.second.row_index = rows_q;
    push.second.final_row = 1'b1;
    above_d = above_q;
    mid_d   = mid_q;
    rows_d  = rows_q;
    if (accept) begin
      if (first_row) begin
        if (single) begin
          push.first_vld       = 1'b1;
          push.first.row_index = '0;
          push.first.final_row = 1'b1;
          above_d = '0;
          mid_d   = '0;
          rows_d  = '0;
        end else begin
          above_d = '0;
          mid_d   = cur;
          rows_d  = lgrs_pkg::IDX_W'(1);
        end
      end else begin
        push.first_vld = 1'b1;
        if (last_row) begin
          push.second_vld = 1'b1;
          above_d = '0;
          mid_d   = '0;
          rows_d  = '0;
        end else begin
          above_d = mid_q;
          mid_d   = cur;
          rows_d  = rows_q + lgrs_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == lgrs_pkg::CFG_GRID_WIDTH) begin
        width_d = cfg_i.data[lgrs_pkg::WIDTH_W-1:0];
      end else if (cfg_i.index == lgrs_pkg::CFG_GRID_HEIGHT) begin
        height_d = cfg_i.data[lgrs_pkg::HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lgrs_pkg::WIDTH_RESET;
      height_q <= lgrs_pkg::HEIGHT_RESET;
      above_q  <= '0;
      mid_q    <= '0;
      rows_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      above_q  <= above_d;
      mid_q    <= mid_d;
      rows_q   <= rows_d;
    end
  end

  lgrs_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_first_row_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_row && !single) |-> !push.first_vld)
    else $error("result pushed for the first row of a multi-row grid");

  a_flush_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.second_vld |=> (rows_q == '0))
    else $error("row count not cleared after flush");

  a_row_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !push.second_vld && !single) |=>
    (rows_q == $past(rows_q) + lgrs_pkg::IDX_W'(1)))
    else $error("row count did not advance");
`endif

endmodule
